>>> hdl/lbcs_pkg.sv
package lbcs_pkg;

  localparam int NUM_BLOCKS      = 256;
  localparam int BYTES_PER_BLOCK = 512;
  localparam int NUM_FILES       = 32;

  localparam int BLK_AW  = $clog2(NUM_BLOCKS);
  localparam int OFF_W   = $clog2(BYTES_PER_BLOCK);
  localparam int BYTE_AW = BLK_AW + OFF_W;
  localparam int SLOT_AW = $clog2(NUM_FILES);
  localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);

  // transaction field widths
  localparam int REQ_W    = 2;
  localparam int SLOT_W   = 5;
  localparam int POS_W    = 17;
  localparam int BYTE_W   = 8;
  localparam int LEN_W    = 18;
  localparam int STATUS_W = 3;
  localparam int HEAD_W   = 8;
  localparam int STEP_W   = POS_W - OFF_W;

  // link entries
  localparam int LINK_W = 9;
  localparam logic [LINK_W-1:0] LINK_FREE = '1;
  localparam logic [LINK_W-1:0] LINK_END  = {{(LINK_W-1){1'b1}}, 1'b0};

  // configuration registers
  localparam int BC_W    = 9;
  localparam int SC_W    = 6;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;
  localparam logic [BC_W-1:0] BC_RESET = 9'd256;
  localparam logic [SC_W-1:0] SC_RESET = 6'd32;
  localparam logic REG_BLOCK_COUNT = 1'b0;
  localparam logic REG_SLOT_COUNT  = 1'b1;

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE   = 2'd0,
    REQ_READ    = 2'd1,
    REQ_RELEASE = 2'd2,
    REQ_CREATE  = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_BAD_SLOT = 3'd1,
    ST_NO_BLOCK = 3'd2,
    ST_BROKEN   = 3'd3,
    ST_NO_SLOT  = 3'd4,
    ST_PAST_END = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    ALLOC_CREATE,
    ALLOC_HEAD,
    ALLOC_TAIL
  } alloc_tgt_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND_SLOT,
    S_SLOT_RD,
    S_WALK,
    S_LINK_RD,
    S_DATA_RD,
    S_SCAN_RD,
    S_SCAN_CK,
    S_CLEAR,
    S_ALLOC_DONE,
    S_REL,
    S_REL_RD,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic [LINK_W-1:0] blocks;
    logic [SC_W-1:0]   slots;
  } cfg_eff_t;

  typedef struct packed {
    logic              rd_en;
    logic [BLK_AW-1:0] rd_addr;
    logic              wr_en;
    logic [BLK_AW-1:0] wr_addr;
    logic [LINK_W-1:0] wr_data;
  } link_req_t;

  typedef struct packed {
    logic               rd_en;
    logic               wr_en;
    logic [BYTE_AW-1:0] addr;
    logic [BYTE_W-1:0]  wr_data;
  } byte_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [SLOT_AW-1:0] rd_addr;
    logic               wr_en;
    logic               clr_en;
    logic [SLOT_AW-1:0] wr_addr;
    logic [LINK_W-1:0]  wr_head;
    logic [LEN_W-1:0]   wr_len;
  } slot_req_t;

endpackage

>>> hdl/lbcs_ifs.sv
interface lbcs_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbcs_pkg::REQ_W-1:0]   req_type;
  logic [lbcs_pkg::SLOT_W-1:0]  file_slot;
  logic [lbcs_pkg::POS_W-1:0]   byte_position;
  logic [lbcs_pkg::BYTE_W-1:0]  write_value;
  logic [lbcs_pkg::LEN_W-1:0]   initial_length;

  modport source (output valid, req_type, file_slot, byte_position, write_value,
                  initial_length, input ready);
  modport sink   (input valid, req_type, file_slot, byte_position, write_value,
                  initial_length, output ready);
endinterface

interface lbcs_out_if;
  logic                           valid;
  logic                           ready;
  logic [lbcs_pkg::STATUS_W-1:0]  status;
  logic [lbcs_pkg::SLOT_W-1:0]    slot_out;
  logic [lbcs_pkg::HEAD_W-1:0]    head_out;
  logic [lbcs_pkg::BYTE_W-1:0]    read_value;
  logic [lbcs_pkg::LEN_W-1:0]     length_out;

  modport source (output valid, status, slot_out, head_out, read_value, length_out,
                  input ready);
  modport sink   (input valid, status, slot_out, head_out, read_value, length_out,
                  output ready);
endinterface

>>> hdl/lbcs_cfg.sv
module lbcs_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbcs_pkg::APB_AW-1:0] paddr,
  input  logic [lbcs_pkg::APB_DW-1:0] pwdata,
  output logic [lbcs_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output lbcs_pkg::cfg_eff_t          eff
);
  import lbcs_pkg::*;

  logic [BC_W-1:0] bc_r;
  logic [SC_W-1:0] sc_r;
  logic            wr_fire;

  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bc_r <= BC_RESET;
      sc_r <= SC_RESET;
    end else if (wr_fire) begin
      unique case (paddr[2])
        REG_BLOCK_COUNT: bc_r <= pwdata[BC_W-1:0];
        REG_SLOT_COUNT:  sc_r <= pwdata[SC_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BLOCK_COUNT: prdata = {{(APB_DW-BC_W){1'b0}}, bc_r};
      REG_SLOT_COUNT:  prdata = {{(APB_DW-SC_W){1'b0}}, sc_r};
      default:         prdata = '0;
    endcase
  end

  // clamp to the built sizes
  assign eff.blocks = (bc_r > LINK_W'(NUM_BLOCKS)) ? LINK_W'(NUM_BLOCKS) : LINK_W'(bc_r);
  assign eff.slots  = (sc_r > SC_W'(NUM_FILES)) ? SC_W'(NUM_FILES) : sc_r;

endmodule

>>> hdl/lbcs_link_mem.sv
module lbcs_link_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lbcs_pkg::link_req_t         req,
  output logic [lbcs_pkg::LINK_W-1:0] rdata
);
  import lbcs_pkg::*;

  logic [LINK_W-1:0]     mem [NUM_BLOCKS];
  logic [NUM_BLOCKS-1:0] vld_r;
  logic [LINK_W-1:0]     data_r;
  logic                  rvld_r;

  // written entries; an unwritten entry reads as free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_r <= mem[req.rd_addr];
      rvld_r <= vld_r[req.rd_addr];
    end
  end

  assign rdata = rvld_r ? data_r : LINK_FREE;

endmodule

>>> hdl/lbcs_byte_mem.sv
module lbcs_byte_mem (
  input  logic                        clk,
  input  lbcs_pkg::byte_req_t         req,
  output logic [lbcs_pkg::BYTE_W-1:0] rdata
);
  import lbcs_pkg::*;

  logic [BYTE_W-1:0] mem [NUM_BLOCKS*BYTES_PER_BLOCK];
  logic [BYTE_W-1:0] data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      data_r <= mem[req.addr];
    end
  end

  assign rdata = data_r;

endmodule

>>> hdl/lbcs_slot_mem.sv
module lbcs_slot_mem (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lbcs_pkg::slot_req_t          req,
  output logic [lbcs_pkg::LINK_W-1:0]  rd_head,
  output logic [lbcs_pkg::LEN_W-1:0]   rd_len,
  output logic [lbcs_pkg::NUM_FILES-1:0] used
);
  import lbcs_pkg::*;

  logic [LINK_W-1:0]    head_mem [NUM_FILES];
  logic [LEN_W-1:0]     len_mem  [NUM_FILES];
  logic [NUM_FILES-1:0] used_r;
  logic [LINK_W-1:0]    head_r;
  logic [LEN_W-1:0]     len_r;
  logic                 rused_r;

  // a slot in use has a head; a free slot has none and zero length
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (req.wr_en) begin
      used_r[req.wr_addr] <= 1'b1;
    end else if (req.clr_en) begin
      used_r[req.wr_addr] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      head_mem[req.wr_addr] <= req.wr_head;
      len_mem[req.wr_addr]  <= req.wr_len;
    end
    if (req.rd_en) begin
      head_r  <= head_mem[req.rd_addr];
      len_r   <= len_mem[req.rd_addr];
      rused_r <= used_r[req.rd_addr];
    end
  end

  assign rd_head = rused_r ? head_r : LINK_FREE;
  assign rd_len  = rused_r ? len_r : '0;
  assign used    = used_r;

endmodule

>>> hdl/linked_block_chain_store_core.sv
// a request with a good slot reads that slot and follows links; an allocation finds a free block
//   (create first finds a free slot) and clears it; a release frees and clears each chain block
// one request at a time, the next taken the cycle after the result is registered
// the walk, scan and clear share the link memory's read and write ports and the single byte memory port
// reset (synchronous, rst_n low): all blocks free, all slots free with zero length,
//   block_count 256, file_slot_count 32; no clearing pass is needed
module linked_block_chain_store_core (
  input  logic                        clk,
  input  logic                        rst_n,
  lbcs_in_if.sink                     in_ch,
  lbcs_out_if.source                  out_ch,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbcs_pkg::APB_AW-1:0] paddr,
  input  logic [lbcs_pkg::APB_DW-1:0] pwdata,
  output logic [lbcs_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);
  import lbcs_pkg::*;

  cfg_eff_t  eff;
  link_req_t link_req;
  byte_req_t byte_req;
  slot_req_t slot_req;

  logic [LINK_W-1:0]    link_rdata;
  logic [BYTE_W-1:0]    byte_rdata;
  logic [LINK_W-1:0]    slot_head;
  logic [LEN_W-1:0]     slot_len;
  logic [NUM_FILES-1:0] slot_used;

  state_t state_r, state_nxt;

  // captured request
  req_t              req_r, req_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [BYTE_W-1:0] val_r, val_nxt;
  logic [LEN_W-1:0]  ilen_r, ilen_nxt;

  // walk state
  logic [LINK_W-1:0] head_r, head_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [LINK_W-1:0] rb_r, rb_nxt;
  logic [STEP_W-1:0] steps_r, steps_nxt;
  logic [LINK_W-1:0] nx_r, nx_nxt;
  logic [LINK_W-1:0] scan_r, scan_nxt;
  logic [SC_W-1:0]   sscan_r, sscan_nxt;
  logic [CNT_W-1:0]  rel_cnt_r, rel_cnt_nxt;
  logic [OFF_W-1:0]  clr_cnt_r, clr_cnt_nxt;
  logic              clr_rel_r, clr_rel_nxt;
  alloc_tgt_t        atgt_r, atgt_nxt;

  // pending result
  status_t           res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_slot_r, res_slot_nxt;
  logic [BYTE_W-1:0] res_rd_r, res_rd_nxt;
  logic              res_have_r, res_have_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  status_t           out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [HEAD_W-1:0] out_head_r, out_head_nxt;
  logic [BYTE_W-1:0] out_rd_r, out_rd_nxt;
  logic [LEN_W-1:0]  out_len_r, out_len_nxt;

  // decision terms
  logic              in_fire, out_free, slot_bad;
  logic              steps_zero, rd_past, head_free, head_oob;
  logic              lnk_end, lnk_free, lnk_oob;
  logic              scan_oob, scan_free, clr_last, rel_go;
  logic              fslot_oob, fslot_free;
  logic [LEN_W-1:0]  pos_ext;
  logic [BLK_AW-1:0] clr_blk;

  lbcs_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .eff     (eff)
  );

  lbcs_link_mem u_link (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (link_req),
    .rdata (link_rdata)
  );

  lbcs_byte_mem u_bytes (
    .clk   (clk),
    .req   (byte_req),
    .rdata (byte_rdata)
  );

  lbcs_slot_mem u_slots (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (slot_req),
    .rd_head (slot_head),
    .rd_len  (slot_len),
    .used    (slot_used)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;
  assign slot_bad    = {1'b0, in_ch.file_slot} >= eff.slots;

  assign pos_ext    = {1'b0, pos_r};
  assign steps_zero = (steps_r == '0);
  // slot read data is live in S_SLOT_RD
  assign rd_past    = (pos_ext >= slot_len) || (slot_head == LINK_FREE);
  assign head_free  = (slot_head == LINK_FREE);
  assign head_oob   = (slot_head >= eff.blocks);
  // link read data is live in the cycle after the read
  assign lnk_end    = (link_rdata == LINK_END);
  assign lnk_free   = (link_rdata == LINK_FREE);
  assign lnk_oob    = (link_rdata >= eff.blocks);
  assign scan_oob   = (scan_r >= eff.blocks);
  assign scan_free  = (link_rdata == LINK_FREE);
  assign clr_last   = (clr_cnt_r == '1);
  assign rel_go     = (rel_cnt_r < CNT_W'(NUM_BLOCKS)) && (rb_r < eff.blocks);
  assign fslot_oob  = (sscan_r >= eff.slots);
  assign fslot_free = !slot_used[sscan_r[SLOT_AW-1:0]];
  assign clr_blk    = clr_rel_r ? rb_r[BLK_AW-1:0] : scan_r[BLK_AW-1:0];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_ch.req_type == REQ_CREATE) state_nxt = S_FIND_SLOT;
          else if (slot_bad)                state_nxt = S_EMIT;
          else                              state_nxt = S_SLOT_RD;
        end
      end
      S_FIND_SLOT: begin
        if (fslot_oob)       state_nxt = S_EMIT;
        else if (fslot_free) state_nxt = S_SCAN_RD;
      end
      S_SLOT_RD: begin
        case (req_r)
          REQ_RELEASE: state_nxt = S_REL;
          REQ_READ:    state_nxt = (rd_past || head_oob) ? S_EMIT : S_WALK;
          default: begin
            if (head_free)     state_nxt = S_SCAN_RD;
            else if (head_oob) state_nxt = S_EMIT;
            else               state_nxt = S_WALK;
          end
        endcase
      end
      S_WALK: begin
        if (!steps_zero)            state_nxt = S_LINK_RD;
        else if (req_r == REQ_READ) state_nxt = S_DATA_RD;
        else                        state_nxt = S_EMIT;
      end
      S_LINK_RD: begin
        if (req_r == REQ_READ) begin
          state_nxt = (lnk_end || lnk_free || lnk_oob) ? S_EMIT : S_WALK;
        end else begin
          if (lnk_free)     state_nxt = S_EMIT;
          else if (lnk_end) state_nxt = S_SCAN_RD;
          else if (lnk_oob) state_nxt = S_EMIT;
          else              state_nxt = S_WALK;
        end
      end
      S_DATA_RD:    state_nxt = S_EMIT;
      S_SCAN_RD:    state_nxt = scan_oob ? S_EMIT : S_SCAN_CK;
      S_SCAN_CK:    state_nxt = scan_free ? S_CLEAR : S_SCAN_RD;
      S_CLEAR: begin
        if (clr_last) state_nxt = clr_rel_r ? S_REL : S_ALLOC_DONE;
      end
      S_ALLOC_DONE: state_nxt = (atgt_r == ALLOC_CREATE) ? S_EMIT : S_WALK;
      S_REL:        state_nxt = rel_go ? S_REL_RD : S_EMIT;
      S_REL_RD:     state_nxt = S_CLEAR;
      S_EMIT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default:      state_nxt = S_IDLE;
    endcase
  end

  // datapath and memory requests
  always_comb begin
    req_nxt        = req_r;
    slot_nxt       = slot_r;
    pos_nxt        = pos_r;
    val_nxt        = val_r;
    ilen_nxt       = ilen_r;
    head_nxt       = head_r;
    len_nxt        = len_r;
    rb_nxt         = rb_r;
    steps_nxt      = steps_r;
    nx_nxt         = nx_r;
    scan_nxt       = scan_r;
    sscan_nxt      = sscan_r;
    rel_cnt_nxt    = rel_cnt_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_rel_nxt    = clr_rel_r;
    atgt_nxt       = atgt_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    res_rd_nxt     = res_rd_r;
    res_have_nxt   = res_have_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_head_nxt   = out_head_r;
    out_rd_nxt     = out_rd_r;
    out_len_nxt    = out_len_r;
    link_req       = '0;
    byte_req       = '0;
    slot_req       = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          req_nxt          = req_t'(in_ch.req_type);
          slot_nxt         = in_ch.file_slot;
          pos_nxt          = in_ch.byte_position;
          val_nxt          = in_ch.write_value;
          ilen_nxt         = in_ch.initial_length;
          sscan_nxt        = '0;
          res_slot_nxt     = in_ch.file_slot;
          res_rd_nxt       = '0;
          res_have_nxt     = 1'b0;
          res_status_nxt   = ST_BAD_SLOT;
          slot_req.rd_en   = 1'b1;
          slot_req.rd_addr = in_ch.file_slot[SLOT_AW-1:0];
        end
      end
      S_FIND_SLOT: begin
        if (fslot_oob) begin
          res_status_nxt = ST_NO_SLOT;
        end else if (fslot_free) begin
          atgt_nxt = ALLOC_CREATE;
          scan_nxt = '0;
        end else begin
          sscan_nxt = sscan_r + 1'b1;
        end
      end
      S_SLOT_RD: begin
        head_nxt     = slot_head;
        len_nxt      = slot_len;
        rb_nxt       = slot_head;
        steps_nxt    = pos_r[POS_W-1:OFF_W];
        res_have_nxt = 1'b1;
        rel_cnt_nxt  = '0;
        case (req_r)
          REQ_RELEASE: ;
          REQ_READ: begin
            if (rd_past)       res_status_nxt = ST_PAST_END;
            else if (head_oob) res_status_nxt = ST_BROKEN;
          end
          default: begin
            if (head_free) begin
              atgt_nxt = ALLOC_HEAD;
              scan_nxt = '0;
            end else if (head_oob) begin
              res_status_nxt = ST_BROKEN;
            end
          end
        endcase
      end
      S_WALK: begin
        if (!steps_zero) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = rb_r[BLK_AW-1:0];
        end else if (req_r == REQ_READ) begin
          byte_req.rd_en = 1'b1;
          byte_req.addr  = {rb_r[BLK_AW-1:0], pos_r[OFF_W-1:0]};
        end else begin
          // store the byte and grow the length when writing at or past the end
          byte_req.wr_en   = 1'b1;
          byte_req.addr    = {rb_r[BLK_AW-1:0], pos_r[OFF_W-1:0]};
          byte_req.wr_data = val_r;
          if (pos_ext >= len_r) len_nxt = pos_ext + 1'b1;
          slot_req.wr_en   = 1'b1;
          slot_req.wr_addr = slot_r[SLOT_AW-1:0];
          slot_req.wr_head = head_r;
          slot_req.wr_len  = (pos_ext >= len_r) ? pos_ext + 1'b1 : len_r;
          res_status_nxt   = ST_OK;
        end
      end
      S_LINK_RD: begin
        if (req_r == REQ_READ) begin
          if (lnk_end) begin
            res_status_nxt = ST_PAST_END;
          end else if (lnk_free || lnk_oob) begin
            res_status_nxt = ST_BROKEN;
          end else begin
            rb_nxt    = link_rdata;
            steps_nxt = steps_r - 1'b1;
          end
        end else begin
          if (lnk_free) begin
            res_status_nxt = ST_BROKEN;
          end else if (lnk_end) begin
            // chain ends early: append a fresh block
            atgt_nxt = ALLOC_TAIL;
            scan_nxt = '0;
          end else if (lnk_oob) begin
            res_status_nxt = ST_BROKEN;
          end else begin
            rb_nxt    = link_rdata;
            steps_nxt = steps_r - 1'b1;
          end
        end
      end
      S_DATA_RD: begin
        res_rd_nxt     = byte_rdata;
        res_status_nxt = ST_OK;
      end
      S_SCAN_RD: begin
        if (scan_oob) begin
          res_status_nxt = ST_NO_BLOCK;
          if (atgt_r == ALLOC_CREATE) res_have_nxt = 1'b0;
        end else begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = scan_r[BLK_AW-1:0];
        end
      end
      S_SCAN_CK: begin
        if (scan_free) begin
          link_req.wr_en   = 1'b1;
          link_req.wr_addr = scan_r[BLK_AW-1:0];
          link_req.wr_data = LINK_END;
          clr_cnt_nxt      = '0;
          clr_rel_nxt      = 1'b0;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      S_CLEAR: begin
        byte_req.wr_en   = 1'b1;
        byte_req.addr    = {clr_blk, clr_cnt_r};
        byte_req.wr_data = '0;
        clr_cnt_nxt      = clr_cnt_r + 1'b1;
        if (clr_last && clr_rel_r) begin
          rb_nxt      = nx_r;
          rel_cnt_nxt = rel_cnt_r + 1'b1;
        end
      end
      S_ALLOC_DONE: begin
        case (atgt_r)
          ALLOC_CREATE: begin
            slot_req.wr_en   = 1'b1;
            slot_req.wr_addr = sscan_r[SLOT_AW-1:0];
            slot_req.wr_head = scan_r;
            slot_req.wr_len  = ilen_r;
            head_nxt         = scan_r;
            len_nxt          = ilen_r;
            res_slot_nxt     = SLOT_W'(sscan_r);
            res_have_nxt     = 1'b1;
            res_status_nxt   = ST_OK;
          end
          ALLOC_HEAD: begin
            slot_req.wr_en   = 1'b1;
            slot_req.wr_addr = slot_r[SLOT_AW-1:0];
            slot_req.wr_head = scan_r;
            slot_req.wr_len  = len_r;
            head_nxt         = scan_r;
            rb_nxt           = scan_r;
          end
          default: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = rb_r[BLK_AW-1:0];
            link_req.wr_data = scan_r;
            rb_nxt           = scan_r;
            steps_nxt        = steps_r - 1'b1;
          end
        endcase
      end
      S_REL: begin
        if (rel_go) begin
          link_req.rd_en   = 1'b1;
          link_req.rd_addr = rb_r[BLK_AW-1:0];
        end else begin
          slot_req.clr_en  = 1'b1;
          slot_req.wr_addr = slot_r[SLOT_AW-1:0];
          head_nxt         = LINK_FREE;
          len_nxt          = '0;
          res_status_nxt   = ST_OK;
        end
      end
      S_REL_RD: begin
        nx_nxt           = link_rdata;
        link_req.wr_en   = 1'b1;
        link_req.wr_addr = rb_r[BLK_AW-1:0];
        link_req.wr_data = LINK_FREE;
        clr_cnt_nxt      = '0;
        clr_rel_nxt      = 1'b1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_slot_nxt   = res_slot_r;
          out_rd_nxt     = res_rd_r;
          out_head_nxt   = (res_have_r && head_r < LINK_W'(NUM_BLOCKS)) ?
                           head_r[HEAD_W-1:0] : '0;
          out_len_nxt    = res_have_r ? len_r : '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r        <= req_nxt;
    slot_r       <= slot_nxt;
    pos_r        <= pos_nxt;
    val_r        <= val_nxt;
    ilen_r       <= ilen_nxt;
    head_r       <= head_nxt;
    len_r        <= len_nxt;
    rb_r         <= rb_nxt;
    steps_r      <= steps_nxt;
    nx_r         <= nx_nxt;
    scan_r       <= scan_nxt;
    sscan_r      <= sscan_nxt;
    rel_cnt_r    <= rel_cnt_nxt;
    clr_cnt_r    <= clr_cnt_nxt;
    clr_rel_r    <= clr_rel_nxt;
    atgt_r       <= atgt_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
    res_rd_r     <= res_rd_nxt;
    res_have_r   <= res_have_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_head_r   <= out_head_nxt;
    out_rd_r     <= out_rd_nxt;
    out_len_r    <= out_len_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.slot_out   = out_slot_r;
  assign out_ch.head_out   = out_head_r;
  assign out_ch.read_value = out_rd_r;
  assign out_ch.length_out = out_len_r;

`ifndef NO_ASSERTIONS
  // an accepted transaction always leaves idle
  a_leave_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != S_IDLE)
    else $error("request accepted but controller stayed idle");

  // a bad slot reports no head and no length
  a_bad_slot_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_BAD_SLOT) |->
      (out_ch.head_out == '0 && out_ch.length_out == '0))
    else $error("bad slot result carries slot state");

  // end marks are only written by the first-fit allocator
  a_end_from_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    (link_req.wr_en && link_req.wr_data == LINK_END) |-> state_r == S_SCAN_CK)
    else $error("end mark written outside allocation");

  // only a successful read returns data
  a_read_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.read_value != '0) |-> out_ch.status == ST_OK)
    else $error("read data returned with error status");
`endif

endmodule
